[hw/rtl/softmax_argmax_ten_core_macros.svh]
// Assertion macros for the softmax block checker
`ifndef SOFTMAX_ARGMAX_TEN_CORE_MACROS_SVH
`define SOFTMAX_ARGMAX_TEN_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMAX_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smax checker: same-cycle property failed");

// next-cycle implication, sampled on clk, off during reset
`define SMAX_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smax checker: next-cycle property failed");

`endif

[hw/rtl/smax_pkg.sv]
// Shared types, constants and the exp table of the softmax block
package smax_pkg;

	localparam int NUM_CLASSES = 10;
	localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int LOGIT_W     = 16;
	localparam int PROB_W      = 16;
	localparam int OUT_IDX_W   = 6;
	localparam int EXP_W       = 17;
	localparam int SUM_W       = 20;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;

	typedef logic signed [LOGIT_W-1:0] logit_t;
	typedef logic [LOGIT_W-1:0]        delta_t;
	typedef logic [PROB_W-1:0]         prob_t;
	typedef logic [OUT_IDX_W-1:0]      out_idx_t;
	typedef logic [CLS_W-1:0]          cls_t;
	typedef logic [EXP_W-1:0]          expv_t;
	typedef logic [SUM_W-1:0]          sum_t;

	localparam cls_t LAST_CLS = CLS_W'(NUM_CLASSES - 1);

	function automatic logic [16:0] pow2_val(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62758;
			5'd2:    v = 17'd60098;
			5'd3:    v = 17'd57550;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/smax_ram.sv]
// Generic single-write, single-read RAM with registered read data
module smax_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/smax_exp.sv]
// Two-stage exp(-t) unit: log2e multiply, then table interpolation and shift
module smax_exp (
	input  logic            clk,
	input  smax_pkg::delta_t delta,
	output smax_pkg::expv_t  ex
);
	import smax_pkg::*;

	logic [32:0] u_s1;
	logic [16:0] m_s2;
	logic [4:0]  n_s2;
	logic        zero_s2;

	logic [3:0]  k;
	logic [7:0]  r;
	logic [16:0] tk;
	logic [16:0] tk1;
	logic [11:0] d;
	logic [19:0] prod;
	logic [16:0] m;
	logic [17:0] rnd;

	always_comb begin
		k    = u_s1[23:20];
		r    = u_s1[19:12];
		tk   = pow2_val({1'b0, k});
		tk1  = pow2_val({1'b0, k} + 5'd1);
		d    = 12'(tk - tk1);
		prod = 20'(d * r);
		m    = tk - 17'((prod + 20'd128) >> 8);
	end

	always_ff @(posedge clk) begin
		u_s1    <= 33'(delta) * 33'(LOG2E_Q16);
		m_s2    <= m;
		n_s2    <= u_s1[28:24];
		zero_s2 <= (u_s1[32:24] > 9'd16);
	end

	always_comb begin
		if (n_s2 == 5'd0) begin
			rnd = 18'(m_s2);
		end else begin
			rnd = 18'(m_s2) + (18'd1 << (n_s2 - 5'd1));
		end
		ex = zero_s2 ? '0 : 17'(rnd >> n_s2);
	end

endmodule

[hw/rtl/smax_div.sv]
// Radix-2 restoring divider for exp / sum, rounded, saturated to 16 bits
module smax_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  smax_pkg::expv_t  ex,
	input  smax_pkg::sum_t   sum,
	output logic             done,
	output smax_pkg::prob_t  quo
);
	import smax_pkg::*;

	localparam int Q_BITS = 17;

	logic              active_q;
	logic [4:0]        cnt_q;
	logic [SUM_W-1:0]  rem_q;
	logic [Q_BITS-1:0] low_q;
	logic [Q_BITS-1:0] q_q;
	logic              zero_q;
	logic [32:0]       num;
	logic [SUM_W:0]    rem2;
	logic              ge;

	always_comb begin
		num  = {ex, 16'd0} + 33'(sum >> 1);
		rem2 = {rem_q, low_q[Q_BITS-1]};
		ge   = (rem2 >= {1'b0, sum});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= 5'(Q_BITS);
			end else if (active_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					active_q <= 1'b0;
					done     <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= SUM_W'(num[32:Q_BITS]);
			low_q  <= num[Q_BITS-1:0];
			q_q    <= '0;
			zero_q <= (sum == '0);
		end else if (active_q) begin
			rem_q <= ge ? SUM_W'(rem2 - {1'b0, sum}) : rem2[SUM_W-1:0];
			low_q <= {low_q[Q_BITS-2:0], 1'b0};
			q_q   <= {q_q[Q_BITS-2:0], ge};
		end
	end

	always_comb begin
		if (zero_q) begin
			quo = '0;
		end else if (q_q[Q_BITS-1]) begin
			quo = '1;
		end else begin
			quo = q_q[PROB_W-1:0];
		end
	end

endmodule

[hw/rtl/softmax_argmax_ten_core.sv]
// Top level of the softmax block: score and exp memories, sequencer, outputs
//
// Usage: drive logit_value (signed Q7.8) with start; an item is taken at a
// rising edge where start is high and busy is low. One item is one class
// score, in class order. Loading an item yields no result. The item that
// completes the vector raises busy. The block then walks the score memory
// once to form exp(score - max), paced by the memory read and the two exp
// stages, and sums them. It then walks the exp memory, one 17-step divider
// pass per class. Each probability is shown for one cycle with result_valid,
// together with class_index, top_class and is_last; the receiver cannot
// stall, so results leave as they are made. After the vector completes,
// busy falls in the cycle of the final result. Reset clears the sequencer,
// the count, the maximum and the sum; the score and exp memories need no
// clearing.
module softmax_argmax_ten_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  smax_pkg::logit_t   logit_value,
	output logic               result_valid,
	output smax_pkg::prob_t    probability,
	output smax_pkg::out_idx_t class_index,
	output smax_pkg::out_idx_t top_class,
	output logic               is_last
);
	import smax_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EXP_RD,
		ST_EXP_T,
		ST_EXP_M,
		ST_EXP_W,
		ST_DIV_RD,
		ST_DIV_GO,
		ST_DIV_WAIT
	} state_t;

	state_t state_q;
	cls_t   load_cnt_q;
	cls_t   idx_q;
	logit_t max_q;
	cls_t   max_idx_q;
	sum_t   sum_q;

	logic   accept;
	logit_t score_rd;
	expv_t  exp_rd;
	delta_t delta;
	expv_t  ex;
	logic   div_done;
	prob_t  quo;
	logic [SUM_W:0] sum_nxt;

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign delta  = delta_t'(max_q - score_rd);
	assign sum_nxt = {1'b0, sum_q} + (SUM_W+1)'(ex);

	smax_ram #(.WIDTH(LOGIT_W), .DEPTH(NUM_CLASSES)) u_score_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (load_cnt_q),
		.wdata (logit_value),
		.raddr (idx_q),
		.rdata (score_rd)
	);

	smax_ram #(.WIDTH(EXP_W), .DEPTH(NUM_CLASSES)) u_exp_ram (
		.clk   (clk),
		.we    (state_q == ST_EXP_W),
		.waddr (idx_q),
		.wdata (ex),
		.raddr (idx_q),
		.rdata (exp_rd)
	);

	smax_exp u_exp (
		.clk   (clk),
		.delta (delta),
		.ex    (ex)
	);

	smax_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (state_q == ST_DIV_GO),
		.ex     (exp_rd),
		.sum    (sum_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_cnt_q   <= '0;
			idx_q        <= '0;
			max_q        <= {1'b1, {(LOGIT_W-1){1'b0}}};
			max_idx_q    <= '0;
			sum_q        <= '0;
			result_valid <= 1'b0;
			probability  <= '0;
			class_index  <= '0;
			top_class    <= '0;
			is_last      <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (logit_value > max_q) begin
							max_q     <= logit_value;
							max_idx_q <= load_cnt_q;
						end
						if (load_cnt_q == LAST_CLS) begin
							load_cnt_q <= '0;
							idx_q      <= '0;
							sum_q      <= '0;
							state_q    <= ST_EXP_RD;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				ST_EXP_RD: state_q <= ST_EXP_T;
				ST_EXP_T:  state_q <= ST_EXP_M;
				ST_EXP_M:  state_q <= ST_EXP_W;
				ST_EXP_W: begin
					sum_q <= sum_nxt[SUM_W] ? '1 : sum_nxt[SUM_W-1:0];
					if (idx_q == LAST_CLS) begin
						idx_q   <= '0;
						state_q <= ST_DIV_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_EXP_RD;
					end
				end
				ST_DIV_RD: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						result_valid <= 1'b1;
						probability  <= quo;
						class_index  <= out_idx_t'(idx_q);
						top_class    <= out_idx_t'(max_idx_q);
						is_last      <= (idx_q == LAST_CLS);
						if (idx_q == LAST_CLS) begin
							idx_q     <= '0;
							max_q     <= {1'b1, {(LOGIT_W-1){1'b0}}};
							max_idx_q <= '0;
							sum_q     <= '0;
							state_q   <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DIV_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

[hw/rtl/smax_checker.sv]
// Port-level checker for the softmax block, bound to the top level
`include "softmax_argmax_ten_core_macros.svh"

module smax_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input smax_pkg::out_idx_t class_index,
	input smax_pkg::out_idx_t top_class,
	input logic               is_last
);
	import smax_pkg::*;

	localparam out_idx_t CLS_END = OUT_IDX_W'(NUM_CLASSES);

	`SMAX_ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid)
	`SMAX_ASSERT_NEXT(a_accept_no_result, start && !busy, !result_valid)
	`SMAX_ASSERT_SAME(a_busy_mid_vector, result_valid && !is_last, busy)
	`SMAX_ASSERT_SAME(a_last_class, result_valid && is_last, class_index == CLS_END - 6'd1)
	`SMAX_ASSERT_SAME(a_index_range, result_valid, (class_index < CLS_END) && (top_class < CLS_END))

endmodule

bind softmax_argmax_ten_core smax_checker u_checker (.*);

[sim/softmax_argmax_ten_core_tb.sv]
// Self-checking testbench for softmax_argmax_ten_core: logit vectors in, probabilities checked
module softmax_argmax_ten_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smax_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_VECTORS = 30;

	typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_TIED} spread_mode_t;

	class softmax_scoreboard;
		prob_t       due_prob[$];
		out_idx_t    due_cls[$];
		out_idx_t    due_top[$];
		logic        due_last[$];
		logit_t      logits[NUM_CLASSES];
		int unsigned filled;
		logit_t      peak;
		int unsigned peak_cls;
		int unsigned pow2_frac[17];
		int          errors;
		int          reports;

		function new();
			pow2_frac = '{65536, 62758, 60098, 57550, 55109, 52773, 50535, 48393,
				46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
			errors = 0;
			reports = 0;
			clear_vector();
		endfunction

		function void clear_vector();
			filled = 0;
			peak = logit_t'(16'h8000);
			peak_cls = 0;
		endfunction

		function int pending();
			return due_prob.size();
		endfunction

		// exp(-gap) in Q1.16, gap in Q8.8
		function int unsigned decay_q16(int unsigned gap);
			longint unsigned u;
			int unsigned n, f, k, r, m;
			u = longint'(gap & 32'hFFFF) * 64'd94548;
			n = int'(u >> 24);
			f = int'((u >> 12) & 64'hFFF);
			k = f >> 8;
			r = f & 32'hFF;
			m = pow2_frac[k] - (((pow2_frac[k] - pow2_frac[k + 1]) * r + 128) >> 8);
			if (n == 0)
				return m;
			if (n > 16)
				return 0;
			return (m + (32'd1 << (n - 1))) >> n;
		endfunction

		function void note_logit(logit_t v);
			int unsigned ex[NUM_CLASSES];
			int unsigned total;
			longint unsigned q;
			int i;
			logits[filled] = v;
			if (v > peak) begin
				peak = v;
				peak_cls = filled;
			end
			filled++;
			if (filled < NUM_CLASSES)
				return;
			total = 0;
			for (i = 0; i < NUM_CLASSES; i++) begin
				ex[i] = decay_q16(int'(peak) - int'(logits[i]));
				total += ex[i];
				if (total > 32'hFFFFF)
					total = 32'hFFFFF;
			end
			for (i = 0; i < NUM_CLASSES; i++) begin
				q = 0;
				if (total != 0) begin
					q = ((longint'(ex[i]) << 16) + longint'(total >> 1)) / longint'(total);
					if (q > 65535)
						q = 65535;
				end
				due_prob.push_back(prob_t'(q));
				due_cls.push_back(out_idx_t'(i));
				due_top.push_back(out_idx_t'(peak_cls));
				due_last.push_back(i == NUM_CLASSES - 1);
			end
			clear_vector();
		endfunction

		function void check_row(prob_t p, out_idx_t c, out_idx_t tc, logic l);
			prob_t    wp;
			out_idx_t wc, wt;
			logic     wl;
			if (due_prob.size() == 0) begin
				errors++;
				if (reports < REPORT_LIMIT)
					$display("unexpected result: prob %0d class %0d top %0d last %0b",
						p, c, tc, l);
				reports++;
				return;
			end
			wp = due_prob.pop_front();
			wc = due_cls.pop_front();
			wt = due_top.pop_front();
			wl = due_last.pop_front();
			if (p !== wp || c !== wc || tc !== wt || l !== wl) begin
				errors++;
				if (reports < REPORT_LIMIT)
					$display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
						wp, wc, wt, wl, p, c, tc, l);
				reports++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logit_t   logit_value = '0;
	logic     busy;
	logic     result_valid;
	prob_t    probability;
	out_idx_t class_index;
	out_idx_t top_class;
	logic     is_last;
	int unsigned cycles = 0;

	softmax_scoreboard sb = new();

	softmax_argmax_ten_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.logit_value  (logit_value),
		.result_valid (result_valid),
		.probability  (probability),
		.class_index  (class_index),
		.top_class    (top_class),
		.is_last      (is_last)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_row(probability, class_index, top_class, is_last);
	end

	task automatic send_logit(input logit_t v, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		logit_value <= v;
		do @(posedge clk); while (busy);
		sb.note_logit(v);
	endtask

	task automatic send_vector(input logit_t vals[NUM_CLASSES], input bit burst);
		int i;
		for (i = 0; i < NUM_CLASSES; i++)
			send_logit(vals[i], burst ? 0 : $urandom_range(0, 8));
	endtask

	// drop start, then hold until every due result is seen
	task automatic drain_results();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_vector(output logit_t vals[NUM_CLASSES]);
		spread_mode_t mode;
		int unsigned base, spread;
		logit_t pick[3];
		int i;
		mode = spread_mode_t'($urandom_range(0, 2));
		base = $urandom_range(0, 65535);
		spread = $urandom_range(0, 3072);
		for (i = 0; i < 3; i++)
			pick[i] = logit_t'(base + $urandom_range(0, spread));
		for (i = 0; i < NUM_CLASSES; i++) begin
			case (mode)
				SPREAD_WIDE: vals[i] = logit_t'($urandom_range(0, 65535));
				SPREAD_NARROW: vals[i] = logit_t'(base + $urandom_range(0, spread));
				default: vals[i] = pick[$urandom_range(0, 2)];
			endcase
		end
	endtask

	initial begin
		logit_t vec[NUM_CLASSES];
		int v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// sole class at the last index, extremes elsewhere
		vec = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0100,
			16'hFF00, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
		send_vector(vec, 1'b0);
		// all equal at the most negative score: ties resolve to class 0
		vec = '{default: logit_t'(16'h8000)};
		send_vector(vec, 1'b1);
		drain_results();
		for (v = 0; v < RANDOM_VECTORS; v++) begin
			random_vector(vec);
			send_vector(vec, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[softmax_argmax_ten_core.f]
+incdir+hw/rtl
hw/rtl/smax_pkg.sv
hw/rtl/smax_ram.sv
hw/rtl/smax_exp.sv
hw/rtl/smax_div.sv
hw/rtl/softmax_argmax_ten_core.sv
hw/rtl/smax_checker.sv
sim/softmax_argmax_ten_core_tb.sv
